// ----- src/fkin_pkg.sv -----
// ----------------------------------------------------------------------------
// fkin_pkg
// Types, constants and helper functions for the planar three-link
// forward kinematics core.
// ----------------------------------------------------------------------------
package fkin_pkg;

    localparam int  ANG_W    = 18;
    localparam int  XW       = 34;
    localparam int  LEN_W    = 16;
    localparam int  OUT_W    = 19;
    localparam int  PROD_W   = XW + LEN_W + 1;
    localparam int  SUM_W    = PROD_W + 2;
    localparam int  TABLE_LEN = 24;
    localparam int  NUM_LINKS = 3;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint OUT_LIMIT   = 64'sd196605;

    typedef enum logic [1:0] {
        REG_LEN_1 = 2'd0,
        REG_LEN_2 = 2'd1,
        REG_LEN_3 = 2'd2
    } t_reg_idx;

    typedef logic signed [XW-1:0] t_xy;

    localparam t_xy ATAN_Q30 [TABLE_LEN] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543515,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef struct {
        logic                 valid;
        logic [NUM_LINKS-1:0] flip;
        t_xy                  x [NUM_LINKS];
        t_xy                  y [NUM_LINKS];
        t_xy                  z [NUM_LINKS];
    } t_beat;

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // restoring long division, elaboration only
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << i);
            end
        end
        return quo;
    endfunction

    function automatic longint gain_q30(int stages);
        longint unsigned g2;
        int n;
        g2 = 64'd1 << 30;
        n = (stages < TABLE_LEN) ? stages : TABLE_LEN;
        for (int i = 0; i < n; i++) g2 = g2 + (g2 >> (2 * i));
        return longint'(udiv64(64'd1 << 60, isqrt64(g2 << 30)));
    endfunction

endpackage

// ----- src/planar_three_link_forward_kinematics_core.sv -----
// Pipeline order: angle prep, CORDIC stages, then combine.
// Throughput: one beat per cycle; the whole pipeline advances together
// and holds only while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// link lengths with 1.0, 1.0 and 0.8 in Q4.12.
// ----------------------------------------------------------------------------
// planar_three_link_forward_kinematics_core
// Tip position of a planar three-link arm from three joint angles,
// CORDIC sine/cosine per link, APB link length registers.
// ----------------------------------------------------------------------------
module planar_three_link_forward_kinematics_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // joint_angle_1, joint_angle_2, joint_angle_3
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // tip_x, tip_y, 2 bits zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fkin_pkg::*;

    localparam t_xy GAIN = XW'(gain_q30(CORDIC_STAGES));

    logic [NUM_LINKS-1:0][LEN_W-1:0] r_len;
    logic                            w_en;
    logic                            w_out_valid;
    logic signed [OUT_W-1:0]         w_x, w_y;
    t_beat                           w_beat [CORDIC_STAGES+1];
    t_reg_idx                        w_idx;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0] <= 16'd4096;
            r_len[1] <= 16'd4096;
            r_len[2] <= 16'd3277;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_LEN_1: r_len[0] <= pwdata[15:0];
                REG_LEN_2: r_len[1] <= pwdata[15:0];
                REG_LEN_3: r_len[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LEN_1: prdata = {16'd0, r_len[0]};
            REG_LEN_2: prdata = {16'd0, r_len[1]};
            REG_LEN_3: prdata = {16'd0, r_len[2]};
            default:   prdata = '0;
        endcase
    end

    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    fkin_angle_prep #(.GAIN(GAIN)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_q1    (s_axis_tdata[15:0]),
        .i_q2    (s_axis_tdata[31:16]),
        .i_q3    (s_axis_tdata[47:32]),
        .o_beat  (w_beat[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        fkin_cordic_stage #(.STAGE(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    fkin_combine u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_beat  (w_beat[CORDIC_STAGES]),
        .i_len   (r_len),
        .o_valid (w_out_valid),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {2'b00, w_y, w_x};

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_x <= OUT_W'(OUT_LIMIT)) && (w_x >= -OUT_W'(OUT_LIMIT)))
        else $error("tip_x beyond saturation limit");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[3:2] == REG_LEN_1) |=>
        r_len[0] == $past(pwdata[15:0]))
        else $error("link length 1 write lost");

endmodule

// ----- src/fkin_angle_prep.sv -----
// ----------------------------------------------------------------------------
// fkin_angle_prep
// Cumulative joint angles, wrap to [-pi, pi] and fold to [-pi/2, pi/2].
// Two register stages; result seeds the CORDIC pipeline.
// ----------------------------------------------------------------------------
module fkin_angle_prep #(
    parameter logic signed [33:0] GAIN = 34'sd652032874
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_q1,
    input  logic signed [15:0]   i_q2,
    input  logic signed [15:0]   i_q3,
    output fkin_pkg::t_beat      o_beat
);
    import fkin_pkg::*;

    logic                    r_valid;
    logic signed [ANG_W-1:0] r_ang [NUM_LINKS];
    logic signed [ANG_W-1:0] n_ang [NUM_LINKS];
    t_beat                   r_beat;
    t_beat                   n_beat;

    always_comb begin
        n_ang[0] = ANG_W'(i_q1);
        n_ang[1] = n_ang[0] + ANG_W'(i_q2);
        n_ang[2] = n_ang[1] + ANG_W'(i_q3);
    end

    always_comb begin
        longint z;
        longint c;
        longint w;
        n_beat.valid = r_valid;
        for (int l = 0; l < NUM_LINKS; l++) begin
            z = longint'(r_ang[l]) * 64'sd262144;
            w = z;
            for (int k = -4; k <= 4; k++) begin
                c = z - longint'(k) * TWO_PI_Q30;
                if (c >= -PI_Q30 && c <= PI_Q30) w = c;
            end
            n_beat.flip[l] = 1'b0;
            if (w > HALF_PI_Q30) begin
                w = w - PI_Q30;
                n_beat.flip[l] = 1'b1;
            end else if (w < -HALF_PI_Q30) begin
                w = w + PI_Q30;
                n_beat.flip[l] = 1'b1;
            end
            n_beat.z[l] = XW'(w);
            n_beat.x[l] = GAIN;
            n_beat.y[l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- src/fkin_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// fkin_cordic_stage
// One rotation-mode CORDIC iteration for all three links, registered.
// ----------------------------------------------------------------------------
module fkin_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fkin_pkg::t_beat i_beat,
    output fkin_pkg::t_beat o_beat
);
    import fkin_pkg::*;

    t_beat r_beat;
    t_beat n_beat;

    always_comb begin
        n_beat.valid = i_beat.valid;
        n_beat.flip  = i_beat.flip;
        for (int l = 0; l < NUM_LINKS; l++) begin
            if (!i_beat.z[l][XW-1]) begin
                n_beat.x[l] = i_beat.x[l] - (i_beat.y[l] >>> STAGE);
                n_beat.y[l] = i_beat.y[l] + (i_beat.x[l] >>> STAGE);
                n_beat.z[l] = i_beat.z[l] - ATAN_Q30[STAGE];
            end else begin
                n_beat.x[l] = i_beat.x[l] + (i_beat.y[l] >>> STAGE);
                n_beat.y[l] = i_beat.y[l] - (i_beat.x[l] >>> STAGE);
                n_beat.z[l] = i_beat.z[l] + ATAN_Q30[STAGE];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- src/fkin_combine.sv -----
// ----------------------------------------------------------------------------
// fkin_combine
// Residual-angle correction, link length products, sum, round and
// saturate. Three register stages, the last is the output register.
// ----------------------------------------------------------------------------
module fkin_combine (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  fkin_pkg::t_beat                            i_beat,
    input  logic [fkin_pkg::NUM_LINKS-1:0][15:0]       i_len,
    output logic                                       o_valid,
    output logic signed [fkin_pkg::OUT_W-1:0]          o_x,
    output logic signed [fkin_pkg::OUT_W-1:0]          o_y
);
    import fkin_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic [NUM_LINKS-1:0]     r_flip1, r_flip2;
    t_xy                      r_c [NUM_LINKS];
    t_xy                      r_s [NUM_LINKS];
    t_xy                      n_c [NUM_LINKS];
    t_xy                      n_s [NUM_LINKS];
    logic signed [PROD_W-1:0] r_pc [NUM_LINKS];
    logic signed [PROD_W-1:0] r_ps [NUM_LINKS];
    logic signed [PROD_W-1:0] n_pc [NUM_LINKS];
    logic signed [PROD_W-1:0] n_ps [NUM_LINKS];
    logic signed [OUT_W-1:0]  r_x, r_y, n_x, n_y;

    function automatic logic signed [OUT_W-1:0] round_sat(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        r = (s + (SUM_W'(1) <<< 29)) >>> 30;
        if (r > SUM_W'(OUT_LIMIT)) return OUT_W'(OUT_LIMIT);
        if (r < -SUM_W'(OUT_LIMIT)) return -OUT_W'(OUT_LIMIT);
        return OUT_W'(r);
    endfunction

    always_comb begin
        logic signed [2*XW-1:0] pzy;
        logic signed [2*XW-1:0] pzx;
        for (int l = 0; l < NUM_LINKS; l++) begin
            pzy    = i_beat.z[l] * i_beat.y[l];
            pzx    = i_beat.z[l] * i_beat.x[l];
            n_c[l] = i_beat.x[l] - XW'(pzy >>> 30);
            n_s[l] = i_beat.y[l] + XW'(pzx >>> 30);
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LINKS; l++) begin
            n_pc[l] = $signed({1'b0, i_len[l]}) * r_c[l];
            n_ps[l] = $signed({1'b0, i_len[l]}) * r_s[l];
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        sx = '0;
        sy = '0;
        for (int l = 0; l < NUM_LINKS; l++) begin
            if (r_flip2[l]) begin
                sx = sx - SUM_W'(r_pc[l]);
                sy = sy - SUM_W'(r_ps[l]);
            end else begin
                sx = sx + SUM_W'(r_pc[l]);
                sy = sy + SUM_W'(r_ps[l]);
            end
        end
        n_x = round_sat(sx);
        n_y = round_sat(sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_beat.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip1 <= i_beat.flip;
            r_c     <= n_c;
            r_s     <= n_s;
            r_flip2 <= r_flip1;
            r_pc    <= n_pc;
            r_ps    <= n_ps;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    assign o_valid = r_v3;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule
